// ===== hw/rtl/aphsv_pkg.sv =====
// ----------------------------------------------------------------------------
// ARGB to HSV package
// Fixed-point settings, derived widths and shared types of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package aphsv_pkg;

  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned SAT_FRAC_BITS = 12;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned SAT_W   = 13;

  // one hue sector (60 degrees) in hue units
  localparam int unsigned SEG = 60 << HUE_FRAC_BITS;

  // quotient widths: hue quotient <= SEG, saturation quotient <= 2^SAT_FRAC_BITS
  localparam int unsigned QH_W = $clog2(SEG + 1);
  localparam int unsigned QS_W = SAT_FRAC_BITS + 1;
  localparam int unsigned QW   = (QH_W > QS_W) ? QH_W : QS_W;

  // remainder width shared by both dividers
  localparam int unsigned RW = CH_W + QW;

  // signed hue before wrap, range -SEG .. 5*SEG
  localparam int unsigned HS_W = $clog2(6 * SEG) + 1;

  typedef enum logic [1:0] {
    SectRed   = 2'd0,
    SectGreen = 2'd1,
    SectBlue  = 2'd2
  } hue_sector_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [CH_W-1:0]    brightness;
    hue_sector_e        sector;
    logic               neg;
    logic               gray;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/argb_pixel_to_hsv_core.sv =====
// ----------------------------------------------------------------------------
// ARGB pixel to HSV core
// Converts one packed ARGB pixel per clock to alpha, hue, saturation, value.
// ----------------------------------------------------------------------------
// Accepts one pixel every clock; busy_o is never raised. Each item leaves
// as a one-cycle valid_o strobe. The two restoring dividers (hue and
// saturation) run side by side and resolve one quotient bit per pipeline
// stage. The output cannot be stalled.
`default_nettype none

module argb_pixel_to_hsv_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [31:0]                    pixel_argb_i,
  output logic                                valid_o,
  output logic [aphsv_pkg::ALPHA_W-1:0]       alpha_o,
  output logic [aphsv_pkg::HUE_W-1:0]         hue_o,
  output logic [aphsv_pkg::SAT_W-1:0]         saturation_o,
  output logic [aphsv_pkg::CH_W-1:0]          brightness_o,
  output logic                                is_gray_o
);

  localparam int unsigned CW = aphsv_pkg::CH_W;
  localparam int unsigned QW = aphsv_pkg::QW;
  localparam int unsigned RW = aphsv_pkg::RW;
  localparam int unsigned HW = aphsv_pkg::HS_W;

  assign busy_o = 1'b0;

  // stage 1: unpacked channels
  logic                          s1_vld_q;
  logic [aphsv_pkg::ALPHA_W-1:0] s1_a_q;
  logic [CW-1:0]                 s1_r_q, s1_g_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q <= pixel_argb_i[31:24];
    s1_r_q <= pixel_argb_i[23:16];
    s1_g_q <= pixel_argb_i[15:8];
    s1_b_q <= pixel_argb_i[7:0];
  end

  // stage 2: max, min, sector and hue difference
  logic [CW-1:0]           mx_d, mn_d, dlt_d, mag_d;
  logic signed [CW:0]      diff_d;
  aphsv_pkg::hue_sector_e  sect_d;

  always_comb begin
    mx_d = (s1_r_q > s1_g_q) ? ((s1_r_q > s1_b_q) ? s1_r_q : s1_b_q)
                             : ((s1_g_q > s1_b_q) ? s1_g_q : s1_b_q);
    mn_d = (s1_r_q < s1_g_q) ? ((s1_r_q < s1_b_q) ? s1_r_q : s1_b_q)
                             : ((s1_g_q < s1_b_q) ? s1_g_q : s1_b_q);
    dlt_d = mx_d - mn_d;
    if (s1_r_q >= mx_d) begin
      sect_d = aphsv_pkg::SectRed;
      diff_d = $signed({1'b0, s1_g_q}) - $signed({1'b0, s1_b_q});
    end else if (s1_g_q >= mx_d) begin
      sect_d = aphsv_pkg::SectGreen;
      diff_d = $signed({1'b0, s1_b_q}) - $signed({1'b0, s1_r_q});
    end else begin
      sect_d = aphsv_pkg::SectBlue;
      diff_d = $signed({1'b0, s1_r_q}) - $signed({1'b0, s1_g_q});
    end
    mag_d = diff_d[CW] ? CW'(-diff_d) : diff_d[CW-1:0];
  end

  logic             s2_vld_q;
  aphsv_pkg::side_t s2_side_q;
  logic [CW-1:0]    s2_dlt_q, s2_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q.alpha      <= s1_a_q;
    s2_side_q.brightness <= mx_d;
    s2_side_q.sector     <= sect_d;
    s2_side_q.neg        <= diff_d[CW];
    s2_side_q.gray       <= (dlt_d == '0);
    s2_dlt_q             <= dlt_d;
    s2_mag_q             <= mag_d;
  end

  // divider pipeline: index 0 holds dividends, each stage resolves one bit
  logic             dv_vld_q  [QW+1];
  aphsv_pkg::side_t dv_side_q [QW+1];
  logic [RW-1:0]    rem_h_q   [QW+1];
  logic [RW-1:0]    rem_s_q   [QW+1];
  logic [CW-1:0]    den_h_q   [QW+1];
  logic [CW-1:0]    den_s_q   [QW+1];
  logic [QW-1:0]    quo_h_q   [QW+1];
  logic [QW-1:0]    quo_s_q   [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= s2_side_q;
    rem_h_q[0]   <= RW'(aphsv_pkg::SEG) * RW'(s2_mag_q);
    rem_s_q[0]   <= RW'(s2_dlt_q) << aphsv_pkg::SAT_FRAC_BITS;
    den_h_q[0]   <= s2_dlt_q;
    den_s_q[0]   <= s2_side_q.brightness;
    quo_h_q[0]   <= '0;
    quo_s_q[0]   <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned BIT = QW - 1 - k;
    logic [RW-1:0] sub_h, sub_s;
    logic          ge_h, ge_s;

    assign sub_h = RW'(den_h_q[k]) << BIT;
    assign sub_s = RW'(den_s_q[k]) << BIT;
    assign ge_h  = (rem_h_q[k] >= sub_h);
    assign ge_s  = (rem_s_q[k] >= sub_s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_side_q[k+1] <= dv_side_q[k];
      den_h_q[k+1]   <= den_h_q[k];
      den_s_q[k+1]   <= den_s_q[k];
      rem_h_q[k+1]   <= ge_h ? (rem_h_q[k] - sub_h) : rem_h_q[k];
      rem_s_q[k+1]   <= ge_s ? (rem_s_q[k] - sub_s) : rem_s_q[k];
      quo_h_q[k+1]   <= quo_h_q[k] | (QW'(ge_h) << BIT);
      quo_s_q[k+1]   <= quo_s_q[k] | (QW'(ge_s) << BIT);
    end
  end

  // output stage: sector offset, sign and wrap
  aphsv_pkg::side_t     fin_side;
  logic signed [HW-1:0] q_h, off_h, hue_s, hue_w;

  assign fin_side = dv_side_q[QW];

  always_comb begin
    q_h = HW'(quo_h_q[QW][aphsv_pkg::QH_W-1:0]);
    unique case (fin_side.sector)
      aphsv_pkg::SectRed:   off_h = '0;
      aphsv_pkg::SectGreen: off_h = HW'(2 * aphsv_pkg::SEG);
      aphsv_pkg::SectBlue:  off_h = HW'(4 * aphsv_pkg::SEG);
      default:              off_h = '0;
    endcase
    hue_s = fin_side.neg ? (off_h - q_h) : (off_h + q_h);
    hue_w = hue_s[HW-1] ? (hue_s + HW'(6 * aphsv_pkg::SEG)) : hue_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_o      <= fin_side.alpha;
    brightness_o <= fin_side.brightness;
    is_gray_o    <= fin_side.gray;
    if (fin_side.gray) begin
      hue_o        <= '0;
      saturation_o <= '0;
    end else begin
      hue_o        <= aphsv_pkg::HUE_W'(unsigned'(hue_w));
      saturation_o <= aphsv_pkg::SAT_W'(quo_s_q[QW][aphsv_pkg::QS_W-1:0]);
    end
  end

endmodule

`default_nettype wire
